// ===== hdl/efind_pkg.sv =====
// Shared types and constants for the essential fault finder.
// Used by the interfaces, the row memory, the row update logic and the top level.
`timescale 1ns / 1ps
`default_nettype none
package efind_pkg;

  localparam int MAX_VECTORS = 256;
  localparam int MAX_FAULTS  = 4096;
  localparam int VEC_W       = $clog2(MAX_VECTORS);
  localparam int FLT_W       = $clog2(MAX_FAULTS);
  localparam int CNT_W       = 9;
  localparam int OTHER_W     = 8;
  localparam logic [CNT_W-1:0]   COUNT_MAX = {CNT_W{1'b1}};
  localparam logic [OTHER_W-1:0] OTHER_MAX = {OTHER_W{1'b1}};

  typedef enum logic [1:0] {
    OP_ENROLL = 2'd0,
    OP_RECORD = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD
  } state_t;

  // One memory row holds everything known about one fault.
  typedef struct packed {
    logic                   enrolled;
    logic [CNT_W-1:0]       count;
    logic [MAX_VECTORS-1:0] bits;
  } row_t;

  localparam int ROW_W = $bits(row_t);

  typedef struct packed {
    logic               excluded;
    logic               self_detects;
    logic [OTHER_W-1:0] other_count;
    logic               status;
  } result_t;

endpackage
`default_nettype wire

// ===== hdl/efind_if.sv =====
// Valid/ready channel interfaces for the essential fault finder.
// Depend on efind_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none
interface efind_in_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               operation;
  logic [efind_pkg::VEC_W-1:0] vector_index;
  logic [efind_pkg::FLT_W-1:0] fault_id;

  modport source (output valid, output operation, output vector_index, output fault_id,
                  input ready);
  modport sink   (input valid, input operation, input vector_index, input fault_id,
                  output ready);
endinterface

interface efind_out_if;
  logic                          valid;
  logic                          ready;
  logic                          excluded;
  logic                          self_detects;
  logic [efind_pkg::OTHER_W-1:0] other_count;
  logic                          status;

  modport source (output valid, output excluded, output self_detects, output other_count,
                  output status, input ready);
  modport sink   (input valid, input excluded, input self_detects, input other_count,
                  input status, output ready);
endinterface
`default_nettype wire

// ===== hdl/efind_row_mem.sv =====
// Per-fault row memory with one write port and one registered read port.
// A read of the row being written in the same cycle returns the new row.
// Depends on efind_pkg.
`timescale 1ns / 1ps
`default_nettype none
module efind_row_mem (
  input  wire                         clk,
  input  wire                         wr_en,
  input  wire [efind_pkg::FLT_W-1:0]  wr_addr,
  input  wire efind_pkg::row_t        wr_data,
  input  wire                         rd_en,
  input  wire [efind_pkg::FLT_W-1:0]  rd_addr,
  output efind_pkg::row_t             rd_data
);
  import efind_pkg::*;

  row_t mem [MAX_FAULTS];
  row_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ===== hdl/efind_row_update.sv =====
// Modify step of the read-modify-write: new row contents and the result item.
// Depends on efind_pkg.
`timescale 1ns / 1ps
`default_nettype none
module efind_row_update (
  input  wire efind_pkg::op_t             op,
  input  wire [efind_pkg::VEC_W-1:0]      vec,
  input  wire efind_pkg::row_t            row_in,
  output efind_pkg::row_t                 row_out,
  output efind_pkg::result_t              result
);
  import efind_pkg::*;

  logic             self_bit;
  logic [CNT_W-1:0] diff;

  assign self_bit = row_in.bits[vec];

  always_comb begin
    row_out = row_in;
    result  = '0;
    diff    = '0;
    case (op)
      OP_ENROLL: begin
        row_out.enrolled = 1'b1;
      end
      OP_RECORD: begin
        if (self_bit) begin
          result.status = 1'b1;
        end else begin
          row_out.bits[vec] = 1'b1;
          if (row_in.count != COUNT_MAX) begin
            row_out.count = row_in.count + CNT_W'(1);
          end
        end
      end
      OP_QUERY: begin
        if (row_in.count >= CNT_W'(self_bit)) begin
          diff = row_in.count - CNT_W'(self_bit);
        end
        result.self_detects = self_bit;
        if (diff > CNT_W'(OTHER_MAX)) begin
          result.other_count = OTHER_MAX;
        end else begin
          result.other_count = diff[OTHER_W-1:0];
        end
        result.excluded = row_in.enrolled && (diff == '0);
      end
      default: begin
        result = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/essential_fault_finder_unit.sv =====
// Top level of the essential fault finder: control sequencer around the row memory.
// Depends on efind_pkg, efind_if, efind_row_mem and efind_row_update.
//
// Usage:
//   in_ch carries one operation per transfer: enroll a fault, record that a vector
//   detects a fault, or query whether a fault is exclusive to a vector. Every input
//   transfer produces exactly one result transfer on out_ch, in order.
//   Each fault owns one memory row (enrolled mark, detection count, one detection
//   bit per vector). An item reads its row in the cycle it is taken, and the row is
//   modified and written back once the output register is free, when the result is
//   also loaded into the output register, from which it is shown on out_ch.
//   Throughput is one item per cycle while out_ch does not stall: the next item's
//   read overlaps the current write-back, and a read of the row being written is
//   forwarded. After reset the row memory is cleared one row a cycle, through all
//   4096 rows, with in_ch.ready low. If out_ch stalls, one result waits in the
//   output register, one more item waits in the modify stage, and in_ch.ready
//   drops until the result is taken.
`timescale 1ns / 1ps
`default_nettype none
module essential_fault_finder_unit (
  input  wire          clk,
  input  wire          rst_n,
  efind_in_if.sink     in_ch,
  efind_out_if.source  out_ch
);
  import efind_pkg::*;

  state_t            state_r, state_nxt;
  logic [FLT_W-1:0]  clr_addr_r, clr_addr_nxt;
  op_t               op_r;
  logic [VEC_W-1:0]  vec_r;
  logic [FLT_W-1:0]  flt_r;
  logic              out_valid_r, out_valid_nxt;
  result_t           result_r;

  logic              accept;
  logic              out_free;
  logic              load_out;
  logic              wr_en;
  logic [FLT_W-1:0]  wr_addr;
  row_t              wr_data;
  row_t              rd_row;
  row_t              new_row;
  result_t           new_result;

  assign out_free = !out_valid_r || out_ch.ready;
  assign accept   = in_ch.valid && in_ch.ready;

  efind_row_mem u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (accept),
    .rd_addr (in_ch.fault_id),
    .rd_data (rd_row)
  );

  efind_row_update u_update (
    .op      (op_r),
    .vec     (vec_r),
    .row_in  (rd_row),
    .row_out (new_row),
    .result  (new_result)
  );

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    in_ch.ready  = 1'b0;
    wr_en        = 1'b0;
    wr_addr      = flt_r;
    wr_data      = new_row;
    load_out     = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        wr_en        = 1'b1;
        wr_addr      = clr_addr_r;
        wr_data      = '0;
        clr_addr_nxt = clr_addr_r + FLT_W'(1);
        if (clr_addr_r == FLT_W'(MAX_FAULTS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          state_nxt = ST_MOD;
        end
      end
      ST_MOD: begin
        // The row is written back only when the result has a place to go.
        if (out_free) begin
          wr_en       = 1'b1;
          load_out    = 1'b1;
          in_ch.ready = 1'b1;
          state_nxt   = in_ch.valid ? ST_MOD : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= op_t'(in_ch.operation);
      vec_r <= in_ch.vector_index;
      flt_r <= in_ch.fault_id;
    end
    if (load_out) begin
      result_r <= new_result;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.excluded     = result_r.excluded;
  assign out_ch.self_detects = result_r.self_detects;
  assign out_ch.other_count  = result_r.other_count;
  assign out_ch.status       = result_r.status;

endmodule
`default_nettype wire

// ===== hdl/efind_checker.sv =====
// Port-level checks for essential_fault_finder_unit, attached by bind.
// Depends on efind_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
module efind_checker (
  input wire                            clk,
  input wire                            rst_n,
  input wire                            in_ready,
  input wire                            out_valid,
  input wire                            out_ready,
  input wire                            excluded,
  input wire                            self_detects,
  input wire [efind_pkg::OTHER_W-1:0]   other_count,
  input wire                            status
);

  // The row memory is swept after reset, so no input is taken right after it.
  a_no_input_after_reset: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("input accepted during the clearing pass");

  a_no_result_after_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("stalled result dropped");

  // A duplicate record flag only comes from a record, which reports no query fields.
  a_status_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status |-> !excluded && !self_detects && (other_count == '0))
    else $error("duplicate flag with query fields set");

  a_excluded_no_other: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && excluded |-> (other_count == '0))
    else $error("excluded fault has other detecting vectors");

endmodule

bind essential_fault_finder_unit efind_checker u_efind_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .excluded     (out_ch.excluded),
  .self_detects (out_ch.self_detects),
  .other_count  (out_ch.other_count),
  .status       (out_ch.status)
);
`default_nettype wire
